[rtl/ffdsf_pkg.sv]
`default_nettype none

package ffdsf_pkg;

    // FIFO geometry
    localparam int QUEUE_DEPTH = 8192;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int FILL_W   = 14;
    localparam int WORD_W   = 16;
    localparam int CODE_W   = 12;
    localparam int FADE_W   = 17;
    localparam int LOWW_W   = 14;
    localparam int VOL_W    = 16;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;

    // shared multiplier
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int XMAG_W  = 15;
    localparam int XOFF_W  = 17;
    localparam int OMAG_W  = 16;

    localparam logic [FADE_W-1:0]  FADE_ONE   = 17'd65536;
    localparam logic [WORD_W-1:0]  DAC_CTRL   = 16'h3000;
    localparam logic [CODE_W-1:0]  MIDSCALE   = 12'd2048;
    localparam logic [XMAG_W-1:0]  OUT_LIMIT  = 15'd32735;
    localparam logic [MUL_B_W-1:0] FULL_SCALE = 17'd32767;
    localparam logic [MUL_B_W-1:0] CODE_SPAN  = 17'd4095;
    localparam logic [XOFF_W-1:0]  X_OFFSET   = 17'd32768;

    // reset values of the control registers
    localparam logic [FADE_W-1:0] FADE_STEP_RST = 17'd819;
    localparam logic [LOWW_W-1:0] LOW_WATER_RST = 14'd40;
    localparam logic [VOL_W-1:0]  VOLUME_RST    = 16'd16384;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_WATER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME    = 2'd2;

    // request actions
    localparam logic [1:0] ACT_PUSH    = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_CODE,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

[rtl/ffdsf_ram.sv]
`default_nettype none

module ffdsf_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/faded_fifo_dac_sample_feeder.sv]
`default_nettype none

// Audio sample feeder: FIFO, fade envelope, volume and 12-bit DAC word packing.
// Input channel (i_valid / o_stall) carries requests: push a sample, sample tick,
// or restart. Every request yields exactly one result on the output channel
// (o_valid / i_stall): word_valid and dac_word on a tick, accepted on a push,
// and the FIFO fill after the request.
// Sequence: a push, restart or a tick on an empty FIFO goes from idle to ST_OUT,
// which loads the result register. A tick that pops a sample runs through
// ST_READ, ST_MUL2, ST_MUL3, ST_MUL4, ST_CODE and ST_OUT: the sample memory read
// is issued at the accepting edge, then four passes through the single shared
// 32x17 multiplier (fade, full scale, volume, code span), ST_CODE rounds the code
// and ST_OUT loads the output register. The block handles one request at a time
// and holds o_stall high until the result is loaded.
// The result sits in an output register, so a new request is taken while the
// previous result still waits for the receiver; if the receiver stalls, the
// next result is held back until the register frees up.
// Reset (i_rst_n low, synchronous) empties the FIFO, zeroes the fade level and
// loads fade_step 819, low_water 40, volume 16384. Write registers while idle.
module faded_fifo_dac_sample_feeder (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [ffdsf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ffdsf_pkg::CFG_W-1:0]     i_cfg_data,
    // request channel
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [1:0]                      i_action,
    input  wire logic [ffdsf_pkg::SAMPLE_W-1:0]  i_sample,
    // result channel
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_word_valid,
    output logic      [ffdsf_pkg::WORD_W-1:0]    o_dac_word,
    output logic                                 o_accepted,
    output logic      [ffdsf_pkg::FILL_W-1:0]    o_fill
);

    ffdsf_pkg::t_state r_state, n_state;

    logic [ffdsf_pkg::PTR_W-1:0]   r_wp, n_wp;
    logic [ffdsf_pkg::PTR_W-1:0]   r_rp, n_rp;
    logic [ffdsf_pkg::COUNT_W-1:0] r_count, n_count;
    logic [ffdsf_pkg::FADE_W-1:0]  r_fade, n_fade;

    logic [ffdsf_pkg::FADE_W-1:0]  r_fade_step, n_fade_step;
    logic [ffdsf_pkg::LOWW_W-1:0]  r_low_water, n_low_water;
    logic [ffdsf_pkg::VOL_W-1:0]   r_volume, n_volume;

    logic r_out_valid, n_out_valid;

    // payload
    logic                          r_word_valid, n_word_valid;
    logic [ffdsf_pkg::WORD_W-1:0]  r_dac_word, n_dac_word;
    logic                          r_accepted, n_accepted;
    logic [ffdsf_pkg::FILL_W-1:0]  r_fill, n_fill;
    logic                          r_res_word_valid, n_res_word_valid;
    logic [ffdsf_pkg::WORD_W-1:0]  r_res_word, n_res_word;
    logic                          r_res_accepted, n_res_accepted;
    logic                          r_neg, n_neg;
    logic [ffdsf_pkg::PROD_W-1:0]  r_prod, n_prod;

    // datapath
    logic                            accept;
    logic                            out_free;
    logic [ffdsf_pkg::MUL_A_W-1:0]   mul_a;
    logic [ffdsf_pkg::MUL_B_W-1:0]   mul_b;
    logic [ffdsf_pkg::SAMPLE_W-1:0]  ram_rdata;
    logic                            ram_we;
    logic                            ram_re;
    logic [ffdsf_pkg::SAMPLE_W:0]    s_mag;
    logic [ffdsf_pkg::PROD_W-1:0]    sum_o;
    logic [ffdsf_pkg::OMAG_W-1:0]    o_mag;
    logic [ffdsf_pkg::PROD_W-1:0]    sum_x;
    logic [19:0]                     x_full;
    logic [ffdsf_pkg::XMAG_W-1:0]    x_mag;
    logic [ffdsf_pkg::XOFF_W-1:0]    x_off;
    logic [ffdsf_pkg::PROD_W-1:0]    sum_c;
    logic [ffdsf_pkg::CODE_W-1:0]    code;
    logic [ffdsf_pkg::FADE_W-1:0]    fade_dn;
    logic [ffdsf_pkg::FADE_W:0]      fade_sum;
    logic [ffdsf_pkg::FADE_W-1:0]    fade_upv;
    logic [ffdsf_pkg::COUNT_W-1:0]   count_pop;
    logic [ffdsf_pkg::PTR_W-1:0]     wp_inc;
    logic [ffdsf_pkg::PTR_W-1:0]     rp_inc;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != ffdsf_pkg::ST_IDLE);

    ffdsf_ram #(
        .WIDTH (ffdsf_pkg::SAMPLE_W),
        .DEPTH (ffdsf_pkg::QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_sample),
        .i_re    (ram_re),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    assign fade_dn  = (r_fade > r_fade_step) ? (r_fade - r_fade_step) : '0;
    assign fade_sum = {1'b0, r_fade} + {1'b0, r_fade_step};
    assign fade_upv = (fade_sum > {1'b0, ffdsf_pkg::FADE_ONE}) ? ffdsf_pkg::FADE_ONE
                                                              : fade_sum[ffdsf_pkg::FADE_W-1:0];
    assign count_pop = r_count - 1'b1;
    assign wp_inc = (32'(r_wp) == ffdsf_pkg::QUEUE_DEPTH - 1) ? '0 : r_wp + 1'b1;
    assign rp_inc = (32'(r_rp) == ffdsf_pkg::QUEUE_DEPTH - 1) ? '0 : r_rp + 1'b1;

    // magnitude path; signs are restored before the code offset
    assign s_mag  = ram_rdata[ffdsf_pkg::SAMPLE_W-1]
                  ? (17'h10000 - {1'b0, ram_rdata}) : {1'b0, ram_rdata};
    assign sum_o  = r_prod + (ffdsf_pkg::PROD_W'(1) << 30);
    assign o_mag  = sum_o[46:31];
    assign sum_x  = r_prod + ffdsf_pkg::PROD_W'(8192);
    assign x_full = sum_x[33:14];
    assign x_mag  = (x_full > 20'(ffdsf_pkg::OUT_LIMIT)) ? ffdsf_pkg::OUT_LIMIT
                                                        : x_full[ffdsf_pkg::XMAG_W-1:0];
    assign x_off  = r_neg ? (ffdsf_pkg::X_OFFSET - ffdsf_pkg::XOFF_W'(x_mag))
                          : (ffdsf_pkg::X_OFFSET + ffdsf_pkg::XOFF_W'(x_mag));
    assign sum_c  = r_prod + ffdsf_pkg::PROD_W'(32768);
    assign code   = sum_c[27:16];

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            ffdsf_pkg::ST_READ: begin
                mul_a = ffdsf_pkg::MUL_A_W'(s_mag);
                mul_b = r_fade;
            end
            ffdsf_pkg::ST_MUL2: begin
                mul_a = r_prod[ffdsf_pkg::MUL_A_W-1:0];
                mul_b = ffdsf_pkg::FULL_SCALE;
            end
            ffdsf_pkg::ST_MUL3: begin
                mul_a = ffdsf_pkg::MUL_A_W'(o_mag);
                mul_b = ffdsf_pkg::MUL_B_W'(r_volume);
            end
            ffdsf_pkg::ST_MUL4: begin
                mul_a = ffdsf_pkg::MUL_A_W'(x_off);
                mul_b = ffdsf_pkg::CODE_SPAN;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = ffdsf_pkg::PROD_W'(mul_a) * ffdsf_pkg::PROD_W'(mul_b);

    always_comb begin
        n_state          = r_state;
        n_wp             = r_wp;
        n_rp             = r_rp;
        n_count          = r_count;
        n_fade           = r_fade;
        n_fade_step      = r_fade_step;
        n_low_water      = r_low_water;
        n_volume         = r_volume;
        n_out_valid      = r_out_valid;
        n_word_valid     = r_word_valid;
        n_dac_word       = r_dac_word;
        n_accepted       = r_accepted;
        n_fill           = r_fill;
        n_res_word_valid = r_res_word_valid;
        n_res_word       = r_res_word;
        n_res_accepted   = r_res_accepted;
        n_neg            = r_neg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_index)
                ffdsf_pkg::REG_FADE_STEP: n_fade_step = i_cfg_data;
                ffdsf_pkg::REG_LOW_WATER: n_low_water = i_cfg_data[ffdsf_pkg::LOWW_W-1:0];
                ffdsf_pkg::REG_VOLUME:    n_volume    = i_cfg_data[ffdsf_pkg::VOL_W-1:0];
                default: ;
            endcase
        end

        // drop the result once the receiver takes it
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ffdsf_pkg::ST_IDLE: begin
                if (accept) begin
                    n_res_word_valid = 1'b0;
                    n_res_word       = '0;
                    n_res_accepted   = 1'b0;
                    n_state          = ffdsf_pkg::ST_OUT;
                    case (i_action)
                        ffdsf_pkg::ACT_PUSH: begin
                            if (32'(r_count) < ffdsf_pkg::QUEUE_DEPTH) begin
                                ram_we         = 1'b1;
                                n_wp           = wp_inc;
                                n_count        = r_count + 1'b1;
                                n_res_accepted = 1'b1;
                            end
                        end
                        ffdsf_pkg::ACT_TICK: begin
                            n_res_word_valid = 1'b1;
                            if (r_count == '0) begin
                                n_fade     = fade_dn;
                                n_res_word = ffdsf_pkg::DAC_CTRL
                                           | ffdsf_pkg::WORD_W'(ffdsf_pkg::MIDSCALE);
                            end else begin
                                ram_re  = 1'b1;
                                n_rp    = rp_inc;
                                n_count = count_pop;
                                n_fade  = (32'(count_pop) < 32'(r_low_water)) ? fade_dn
                                                                              : fade_upv;
                                n_state = ffdsf_pkg::ST_READ;
                            end
                        end
                        ffdsf_pkg::ACT_RESTART: begin
                            n_wp    = '0;
                            n_rp    = '0;
                            n_count = '0;
                            n_fade  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ffdsf_pkg::ST_READ: begin
                n_neg   = ram_rdata[ffdsf_pkg::SAMPLE_W-1];
                n_state = ffdsf_pkg::ST_MUL2;
            end
            ffdsf_pkg::ST_MUL2: n_state = ffdsf_pkg::ST_MUL3;
            ffdsf_pkg::ST_MUL3: n_state = ffdsf_pkg::ST_MUL4;
            ffdsf_pkg::ST_MUL4: n_state = ffdsf_pkg::ST_CODE;
            ffdsf_pkg::ST_CODE: begin
                n_res_word = ffdsf_pkg::DAC_CTRL | ffdsf_pkg::WORD_W'(code);
                n_state    = ffdsf_pkg::ST_OUT;
            end
            ffdsf_pkg::ST_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_word_valid = r_res_word_valid;
                    n_dac_word   = r_res_word;
                    n_accepted   = r_res_accepted;
                    n_fill       = ffdsf_pkg::FILL_W'(r_count);
                    n_state      = ffdsf_pkg::ST_IDLE;
                end
            end
            default: n_state = ffdsf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffdsf_pkg::ST_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_count     <= '0;
            r_fade      <= '0;
            r_fade_step <= ffdsf_pkg::FADE_STEP_RST;
            r_low_water <= ffdsf_pkg::LOW_WATER_RST;
            r_volume    <= ffdsf_pkg::VOLUME_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_count     <= n_count;
            r_fade      <= n_fade;
            r_fade_step <= n_fade_step;
            r_low_water <= n_low_water;
            r_volume    <= n_volume;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word_valid     <= n_word_valid;
        r_dac_word       <= n_dac_word;
        r_accepted       <= n_accepted;
        r_fill           <= n_fill;
        r_res_word_valid <= n_res_word_valid;
        r_res_word       <= n_res_word;
        r_res_accepted   <= n_res_accepted;
        r_neg            <= n_neg;
        r_prod           <= n_prod;
    end

    assign o_valid      = r_out_valid;
    assign o_word_valid = r_word_valid;
    assign o_dac_word   = r_dac_word;
    assign o_accepted   = r_accepted;
    assign o_fill       = r_fill;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= ffdsf_pkg::QUEUE_DEPTH)
        else $error("FIFO count exceeds depth");

    a_fade_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fade <= ffdsf_pkg::FADE_ONE)
        else $error("fade level above unity");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ffdsf_pkg::ST_IDLE) |=> $stable(r_count))
        else $error("FIFO count moved while a request was in flight");

    a_word_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_word_valid) |-> (r_dac_word[15:12] == 4'b0011))
        else $error("DAC word without control bits");

endmodule

`default_nettype wire

[test/feeder_result_checker.sv]
`timescale 1ns / 1ps

module feeder_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ffdsf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ffdsf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            i_req_valid,
    input  logic                            i_req_stall,
    input  logic [1:0]                      i_action,
    input  logic [ffdsf_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                            i_res_valid,
    input  logic                            i_res_stall,
    input  logic                            i_word_valid,
    input  logic [ffdsf_pkg::WORD_W-1:0]    i_dac_word,
    input  logic                            i_accepted,
    input  logic [ffdsf_pkg::FILL_W-1:0]    i_fill,
    output int                              o_errors,
    output int                              o_outstanding
);

    typedef struct packed {
        logic                         word_valid;
        logic [ffdsf_pkg::WORD_W-1:0] dac_word;
        logic                         accepted;
        logic [ffdsf_pkg::FILL_W-1:0] fill;
    } t_feeder_result;

    logic [ffdsf_pkg::SAMPLE_W-1:0] fifo_model[$];
    t_feeder_result                 pending_results[$];
    logic [ffdsf_pkg::FADE_W-1:0]   fade_lvl;
    logic [ffdsf_pkg::FADE_W-1:0]   fade_step;
    logic [ffdsf_pkg::LOWW_W-1:0]   low_water;
    logic [ffdsf_pkg::VOL_W-1:0]    volume;
    int                             errors;

    function automatic longint round_half_away(longint v, int sh);
        longint half;
        half = longint'(1) <<< (sh - 1);
        if (v >= 0)
            return (v + half) >>> sh;
        return -((-v + half) >>> sh);
    endfunction

    // uses the fade level after this tick's update
    function automatic logic [ffdsf_pkg::CODE_W-1:0] dac_code(
        logic signed [ffdsf_pkg::SAMPLE_W-1:0] s);
        longint faded;
        longint gained;
        faded  = round_half_away(longint'(s) * longint'(fade_lvl)
                                 * longint'(ffdsf_pkg::FULL_SCALE), 31);
        gained = round_half_away(faded * longint'(volume), 14);
        if (gained > longint'(ffdsf_pkg::OUT_LIMIT))
            gained = longint'(ffdsf_pkg::OUT_LIMIT);
        if (gained < -longint'(ffdsf_pkg::OUT_LIMIT))
            gained = -longint'(ffdsf_pkg::OUT_LIMIT);
        return ffdsf_pkg::CODE_W'(((gained + longint'(ffdsf_pkg::X_OFFSET))
                                   * longint'(ffdsf_pkg::CODE_SPAN)
                                   + (longint'(1) <<< 15)) >>> 16);
    endfunction

    function automatic void fade_fall();
        fade_lvl = (fade_lvl > fade_step) ? fade_lvl - fade_step : '0;
    endfunction

    function automatic void fade_rise();
        logic [ffdsf_pkg::FADE_W:0] sum;
        sum = fade_lvl + fade_step;
        fade_lvl = (sum > ffdsf_pkg::FADE_ONE) ? ffdsf_pkg::FADE_ONE
                                               : sum[ffdsf_pkg::FADE_W-1:0];
    endfunction

    function automatic t_feeder_result next_feeder_result(
        logic [1:0] act, logic [ffdsf_pkg::SAMPLE_W-1:0] smp);
        t_feeder_result r;
        logic [ffdsf_pkg::SAMPLE_W-1:0] head;
        r = '0;
        case (act)
            ffdsf_pkg::ACT_PUSH: begin
                // drop when full
                if (fifo_model.size() < ffdsf_pkg::QUEUE_DEPTH) begin
                    fifo_model.push_back(smp);
                    r.accepted = 1'b1;
                end
            end
            ffdsf_pkg::ACT_TICK: begin
                r.word_valid = 1'b1;
                if (fifo_model.size() == 0) begin
                    fade_fall();
                    r.dac_word = ffdsf_pkg::DAC_CTRL
                               | ffdsf_pkg::WORD_W'(ffdsf_pkg::MIDSCALE);
                end else begin
                    head = fifo_model.pop_front();
                    if (fifo_model.size() < low_water)
                        fade_fall();
                    else
                        fade_rise();
                    r.dac_word = ffdsf_pkg::DAC_CTRL | ffdsf_pkg::WORD_W'(dac_code(head));
                end
            end
            ffdsf_pkg::ACT_RESTART: begin
                fifo_model.delete();
                fade_lvl = '0;
            end
            default: ;
        endcase
        r.fill = ffdsf_pkg::FILL_W'(fifo_model.size());
        return r;
    endfunction

    function automatic int field_mismatch(string name, logic [15:0] want, logic [15:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_feeder_result want;
        if (!i_rst_n) begin
            fifo_model.delete();
            pending_results.delete();
            fade_lvl  = '0;
            fade_step = ffdsf_pkg::FADE_STEP_RST;
            low_water = ffdsf_pkg::LOW_WATER_RST;
            volume    = ffdsf_pkg::VOLUME_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ffdsf_pkg::REG_FADE_STEP:
                        fade_step = i_cfg_data[ffdsf_pkg::FADE_W-1:0];
                    ffdsf_pkg::REG_LOW_WATER:
                        low_water = i_cfg_data[ffdsf_pkg::LOWW_W-1:0];
                    ffdsf_pkg::REG_VOLUME:
                        volume    = i_cfg_data[ffdsf_pkg::VOL_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got fill %0d",
                             $time, i_fill);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    errors += field_mismatch("word_valid", 16'(want.word_valid),
                                             16'(i_word_valid));
                    errors += field_mismatch("dac_word", want.dac_word, i_dac_word);
                    errors += field_mismatch("accepted", 16'(want.accepted), 16'(i_accepted));
                    errors += field_mismatch("fill", 16'(want.fill), 16'(i_fill));
                end
            end
            if (i_req_valid && !i_req_stall)
                pending_results.push_back(next_feeder_result(i_action, i_sample));
        end
        o_errors      <= errors;
        o_outstanding <= pending_results.size();
    end

endmodule

[test/faded_fifo_dac_sample_feeder_tb.sv]
`timescale 1ns / 1ps

module faded_fifo_dac_sample_feeder_tb;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 110;
    localparam int DEEP_PUSHES    = 100;
    localparam int DEEP_TICKS     = 70;
    localparam int HOLD_CYCLES    = 400;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [ffdsf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ffdsf_pkg::CFG_W-1:0]     i_cfg_data  = '0;
    logic                            i_valid     = 1'b0;
    logic                            o_stall;
    logic [1:0]                      i_action    = ffdsf_pkg::ACT_PUSH;
    logic [ffdsf_pkg::SAMPLE_W-1:0]  i_sample    = '0;
    logic                            o_valid;
    logic                            i_stall     = 1'b0;
    logic                            o_word_valid;
    logic [ffdsf_pkg::WORD_W-1:0]    o_dac_word;
    logic                            o_accepted;
    logic [ffdsf_pkg::FILL_W-1:0]    o_fill;

    int mismatches;
    int outstanding;
    bit tx_quiet     = 1'b0;
    bit rx_quiet     = 1'b0;
    bit pressure_req = 1'b0;

    faded_fifo_dac_sample_feeder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_word_valid (o_word_valid),
        .o_dac_word   (o_dac_word),
        .o_accepted   (o_accepted),
        .o_fill       (o_fill)
    );

    feeder_result_checker result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_action      (i_action),
        .i_sample      (i_sample),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_word_valid  (o_word_valid),
        .i_dac_word    (o_dac_word),
        .i_accepted    (o_accepted),
        .i_fill        (o_fill),
        .o_errors      (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #12_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (pressure_req) begin
                pressure_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (rx_quiet) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 16);
            end
        end
    end

    // leaves valid high; the caller either sends again or drops it
    task automatic send_request(input logic [1:0] act,
                                input logic [ffdsf_pkg::SAMPLE_W-1:0] smp);
        while (!tx_quiet && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_sample <= smp;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic load_settings(input logic [ffdsf_pkg::FADE_W-1:0] fs,
                                 input logic [ffdsf_pkg::LOWW_W-1:0] lw,
                                 input logic [ffdsf_pkg::VOL_W-1:0]  vol);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ffdsf_pkg::REG_FADE_STEP;
        i_cfg_data  <= ffdsf_pkg::CFG_W'(fs);
        @(posedge i_clk);
        i_cfg_index <= ffdsf_pkg::REG_LOW_WATER;
        i_cfg_data  <= ffdsf_pkg::CFG_W'(lw);
        @(posedge i_clk);
        i_cfg_index <= ffdsf_pkg::REG_VOLUME;
        i_cfg_data  <= ffdsf_pkg::CFG_W'(vol);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [ffdsf_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(15))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return ffdsf_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    initial begin
        int roll;
        int push_pct;
        logic [ffdsf_pkg::FADE_W-1:0] fs;
        logic [ffdsf_pkg::LOWW_W-1:0] lw;
        logic [ffdsf_pkg::VOL_W-1:0]  vol;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: empty tick, unused action, restart, extremes
        send_request(ffdsf_pkg::ACT_TICK, '0);
        send_request(ACT_UNUSED, 16'h1234);
        send_request(ffdsf_pkg::ACT_RESTART, '0);
        send_request(ffdsf_pkg::ACT_PUSH, 16'h7FFF);
        send_request(ffdsf_pkg::ACT_PUSH, 16'h8000);
        send_request(ACT_UNUSED, 16'hFFFF);
        repeat (3) send_request(ffdsf_pkg::ACT_TICK, '0);
        settle();

        // full fade, no low-water, max volume drives the clamp
        load_settings(ffdsf_pkg::FADE_ONE, '0, '1);
        send_request(ffdsf_pkg::ACT_PUSH, 16'h7FFF);
        send_request(ffdsf_pkg::ACT_PUSH, 16'h8000);
        send_request(ffdsf_pkg::ACT_PUSH, 16'h0001);
        send_request(ffdsf_pkg::ACT_PUSH, 16'hFFFF);
        send_request(ffdsf_pkg::ACT_PUSH, 16'h0000);
        send_request(ffdsf_pkg::ACT_PUSH, 16'h3039);
        repeat (7) send_request(ffdsf_pkg::ACT_TICK, '0);
        send_request(ffdsf_pkg::ACT_RESTART, '0);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            fs  = ($urandom_range(3) == 0) ? ffdsf_pkg::FADE_ONE
                                           : ffdsf_pkg::FADE_W'($urandom_range(1, 4096));
            lw  = ($urandom_range(3) == 0)
                ? ffdsf_pkg::LOWW_W'($urandom_range(0, ffdsf_pkg::QUEUE_DEPTH))
                : ffdsf_pkg::LOWW_W'($urandom_range(0, 64));
            vol = ($urandom_range(3) == 0) ? ffdsf_pkg::VOL_W'($urandom)
                                           : ffdsf_pkg::VOL_W'($urandom_range(8192, 32768));
            if (p == 0) begin
                fs  = '0;
                vol = '0;
            end
            load_settings(fs, lw, vol);
            tx_quiet = (p == 3);
            rx_quiet = (p == 3);
            if (p == 1)
                pressure_req = 1'b1;
            push_pct = $urandom_range(35, 65);
            repeat (PHASE_REQUESTS) begin
                roll = $urandom_range(99);
                if (roll < 2)
                    send_request(ffdsf_pkg::ACT_RESTART, ffdsf_pkg::SAMPLE_W'($urandom));
                else if (roll < 4)
                    send_request(ACT_UNUSED, ffdsf_pkg::SAMPLE_W'($urandom));
                else if (roll < 4 + push_pct)
                    send_request(ffdsf_pkg::ACT_PUSH, pick_sample());
                else
                    send_request(ffdsf_pkg::ACT_TICK, ffdsf_pkg::SAMPLE_W'($urandom));
            end
            settle();
        end

        // deep FIFO around low-water: fade rises, then falls below the mark
        load_settings(ffdsf_pkg::FADE_W'($urandom_range(256, 8192)), ffdsf_pkg::LOWW_W'(40),
                      ffdsf_pkg::VOL_W'($urandom));
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_request(ffdsf_pkg::ACT_RESTART, '0);
        repeat (DEEP_PUSHES) send_request(ffdsf_pkg::ACT_PUSH, pick_sample());
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        repeat (DEEP_TICKS) send_request(ffdsf_pkg::ACT_TICK, '0);
        send_request(ffdsf_pkg::ACT_RESTART, '0);
        send_request(ffdsf_pkg::ACT_TICK, '0);
        settle();

        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
rtl/ffdsf_pkg.sv
rtl/ffdsf_ram.sv
rtl/faded_fifo_dac_sample_feeder.sv
test/feeder_result_checker.sv
test/faded_fifo_dac_sample_feeder_tb.sv
